### hw/rtl/scanline_span_merger_macros.svh
// Assertion macros for the span merger.
`ifndef SCANLINE_SPAN_MERGER_MACROS_SVH
`define SCANLINE_SPAN_MERGER_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define SCM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define SCM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/scm_pkg.sv
// Shared constants and types of the span merger.
`default_nettype none
package scm_pkg;
  localparam int LINE_W      = 10;
  localparam int LIM_W       = 13;
  localparam int CFG_IDX_W   = 2;
  localparam int LINES_DEF   = 1024;
  localparam int POOL_DEF    = 4096;
  localparam int X_BITS_DEF  = 12;
  localparam int COLOR_DEF   = 8;

  localparam logic [LIM_W-1:0] LIMIT_RESET = 13'd4096;

  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_POOL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POOL0_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POOL1_LIMIT = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LINE,
    ST_TAIL,
    ST_PREV
  } state_e;
endpackage
`default_nettype wire

### hw/rtl/scanline_span_merger.sv
// Span merger: per-line colour run lists built in two stack-allocated slot pools.
`default_nettype none
// A request is taken when start is high and busy is low; the block then stays busy
// until its one result appears on the tail ports with done_o high for one cycle,
// which the receiver must take as it comes. A line index at or beyond LINES never
// raises busy and answers in the next cycle with all fields zero. Otherwise the
// sequencer walks the single-port line table and the run memory (one registered
// read per cycle) in order: line entry, then for a non-empty line the tail slot,
// then, when a run of another colour is trimmed, the preceding slot and write-back.
// After reset a clearing pass zeroes every entry of the line table; busy is high
// throughout, and configuration writes are taken as ever.
module scanline_span_merger #(
  parameter int LINES      = scm_pkg::LINES_DEF,
  parameter int POOL_DEPTH = scm_pkg::POOL_DEF,
  parameter int X_BITS     = scm_pkg::X_BITS_DEF,
  parameter int COLOR_BITS = scm_pkg::COLOR_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start,
  output      logic                              busy,
  input  wire logic [scm_pkg::LINE_W-1:0]        line_i,
  input  wire logic [X_BITS-1:0]                 span_start_i,
  input  wire logic [X_BITS-1:0]                 span_end_i,
  input  wire logic [COLOR_BITS-1:0]             span_color_i,
  input  wire logic                              cfg_valid_i,
  output      logic                              cfg_ready_o,
  input  wire logic [scm_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [scm_pkg::LIM_W-1:0]         cfg_data_i,
  output      logic                              done_o,
  output      logic                              pool_overflow_o,
  output      logic [$clog2(POOL_DEPTH):0]       line_segments_o,
  output      logic [$clog2(POOL_DEPTH)-1:0]     tail_slot_o,
  output      logic [X_BITS-1:0]                 tail_start_o,
  output      logic [X_BITS:0]                   tail_length_o,
  output      logic [COLOR_BITS-1:0]             tail_color_o
);
  import scm_pkg::*;

  localparam int SLOT_W = $clog2(POOL_DEPTH);
  localparam int ADDR_W = SLOT_W + 1;
  localparam int TOP_W  = SLOT_W + 1;
  localparam int CNT_W  = SLOT_W + 2;
  localparam int LEN_W  = X_BITS + 1;
  localparam int SUM_W  = X_BITS + 2;
  localparam int LIDX_W = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int CMP_W  = (LIM_W > TOP_W) ? LIM_W : TOP_W;
  localparam int LCMP_W = 13;

  typedef struct packed {
    logic [X_BITS-1:0]     start;
    logic [LEN_W-1:0]      len;
    logic [COLOR_BITS-1:0] color;
  } run_t;

  typedef struct packed {
    logic [CNT_W-1:0]  cnt;
    logic [ADDR_W-1:0] tail;
  } line_t;

  typedef struct packed {
    logic                  ovf;
    logic [SLOT_W:0]       cnt;
    logic [SLOT_W-1:0]     slot;
    logic [X_BITS-1:0]     start;
    logic [LEN_W-1:0]      len;
    logic [COLOR_BITS-1:0] color;
  } res_t;

  // Memories
  run_t  run_mem [2*POOL_DEPTH];
  line_t lt_mem  [LINES];

  state_e state_q, state_d;
  logic [LINE_W-1:0]     y_q, y_d;
  logic [X_BITS-1:0]     x0_q, x0_d, x1_q, x1_d;
  logic [COLOR_BITS-1:0] col_q, col_d;
  logic [ADDR_W-1:0]     p_q, p_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  ovf_q, ovf_d;
  logic                  mcand_q, mcand_d;
  logic [TOP_W-1:0]      top0_q, top0_d, top1_q, top1_d;
  logic                  act_q;
  logic [LIM_W-1:0]      lim0_q, lim1_q;
  logic [LIDX_W-1:0]     clr_q, clr_d;
  logic                  res_valid_q, res_valid_d;
  res_t                  res_q, res_d;
  line_t                 lent_q;
  run_t                  rdat_q;

  // Memory control
  logic              rd_en, wr_en, lt_re, lt_we;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  run_t              wr_data;
  logic [LIDX_W-1:0] lt_raddr, lt_waddr;
  line_t             lt_wdata;

  // Shared unit: slot allocation check and the length adder
  logic [TOP_W-1:0]  top_act;
  logic [LIM_W-1:0]  lim_act;
  logic              grab_ok;
  logic [ADDR_W-1:0] grab_addr;
  logic [X_BITS-1:0] len_base;
  logic [LEN_W-1:0]  len_new;
  logic [SUM_W-1:0]  tail_end;
  logic              overlap, adjacent, same_col, extend, merge;
  logic              line_ok;
  logic [ADDR_W-1:0] p_alloc;
  logic [CNT_W-1:0]  cnt_alloc;

  assign top_act   = act_q ? top1_q : top0_q;
  assign lim_act   = act_q ? lim1_q : lim0_q;
  assign grab_ok   = (CMP_W'(top_act) < CMP_W'(lim_act)) &&
                     (top_act < TOP_W'(POOL_DEPTH));
  assign grab_addr = {act_q, top_act[SLOT_W-1:0]};

  assign tail_end  = SUM_W'(rdat_q.start) + SUM_W'(rdat_q.len);
  assign overlap   = tail_end > SUM_W'(x0_q);
  assign adjacent  = tail_end == SUM_W'(x0_q);
  assign same_col  = rdat_q.color == col_q;
  assign extend    = (overlap || adjacent) && same_col;
  assign merge     = mcand_q && same_col;
  assign len_new   = LEN_W'(x1_q) - LEN_W'(len_base) + LEN_W'(1);

  assign line_ok   = {{(LCMP_W-LINE_W){1'b0}}, line_i} < LCMP_W'(LINES);

  // Trim path: new slot if the trimmed run keeps a length and a slot is free
  always_comb begin
    p_alloc   = p_q;
    cnt_alloc = cnt_q;
    if ((x0_q > rdat_q.start) && grab_ok) begin
      p_alloc   = grab_addr;
      cnt_alloc = cnt_q + CNT_W'(1);
    end
  end

  // Length adder operand
  always_comb begin
    len_base = x0_q;
    if ((state_q == ST_TAIL && extend) || (state_q == ST_PREV && merge)) begin
      len_base = rdat_q.start;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_q == LIDX_W'(LINES - 1)) state_d = ST_IDLE;
      ST_IDLE:  if (start && line_ok) state_d = ST_LINE;
      ST_LINE:  if (lent_q.cnt != '0) state_d = ST_TAIL;
                else state_d = ST_IDLE;
      ST_TAIL:  if (overlap && !same_col) state_d = ST_PREV;
                else state_d = ST_IDLE;
      ST_PREV:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    y_d = y_q; x0_d = x0_q; x1_d = x1_q; col_d = col_q;
    p_d = p_q; cnt_d = cnt_q; ovf_d = ovf_q; mcand_d = mcand_q;
    top0_d = top0_q; top1_d = top1_q; clr_d = clr_q;
    res_valid_d = 1'b0; res_d = res_q;
    rd_en = 1'b0; rd_addr = p_q;
    wr_en = 1'b0; wr_addr = p_q; wr_data = '{start: x0_q, len: len_new, color: col_q};
    lt_re = 1'b0; lt_raddr = LIDX_W'(line_i);
    lt_we = 1'b0; lt_waddr = LIDX_W'(y_q); lt_wdata = '{cnt: cnt_q, tail: p_q};
    case (state_q)
      ST_CLEAR: begin
        lt_we    = 1'b1;
        lt_waddr = clr_q;
        lt_wdata = '0;
        clr_d    = clr_q + LIDX_W'(1);
      end
      ST_IDLE: begin
        if (start) begin
          y_d = line_i; x0_d = span_start_i; x1_d = span_end_i; col_d = span_color_i;
          ovf_d = 1'b0;
          if (line_ok) begin
            lt_re = 1'b1;
          end else begin
            res_valid_d = 1'b1;
            res_d       = '0;
          end
        end
      end
      ST_LINE: begin
        if (lent_q.cnt == '0) begin
          res_valid_d = 1'b1;
          res_d       = '0;
          if (grab_ok) begin
            if (act_q) top1_d = top1_q + TOP_W'(1);
            else       top0_d = top0_q + TOP_W'(1);
            wr_en    = 1'b1;
            wr_addr  = grab_addr;
            lt_we    = 1'b1;
            lt_wdata = '{cnt: CNT_W'(1), tail: grab_addr};
            res_d    = '{ovf: 1'b0, cnt: (SLOT_W+1)'(1), slot: grab_addr[SLOT_W-1:0],
                         start: x0_q, len: len_new, color: col_q};
          end else begin
            res_d.ovf = 1'b1;
          end
        end else begin
          rd_en   = 1'b1;
          rd_addr = lent_q.tail;
          p_d     = lent_q.tail;
          cnt_d   = lent_q.cnt;
        end
      end
      ST_TAIL: begin
        if (extend) begin
          // Same colour touching or overlapping: stretch the tail run
          wr_en       = 1'b1;
          wr_data     = '{start: rdat_q.start, len: len_new, color: rdat_q.color};
          res_valid_d = 1'b1;
          res_d       = '{ovf: 1'b0, cnt: cnt_q[SLOT_W:0], slot: p_q[SLOT_W-1:0],
                          start: rdat_q.start, len: len_new, color: rdat_q.color};
        end else if (overlap) begin
          // Other colour overlapping: trim, maybe allocate, then look back one slot
          wr_en   = 1'b1;
          wr_data = '{start: rdat_q.start, len: LEN_W'(x0_q) - LEN_W'(rdat_q.start),
                      color: rdat_q.color};
          if (x0_q > rdat_q.start) begin
            if (grab_ok) begin
              if (act_q) top1_d = top1_q + TOP_W'(1);
              else       top0_d = top0_q + TOP_W'(1);
            end else begin
              ovf_d = 1'b1;
            end
          end
          p_d     = p_alloc;
          cnt_d   = cnt_alloc;
          mcand_d = (p_alloc[SLOT_W-1:0] != '0) && (cnt_alloc > CNT_W'(1));
          rd_en   = 1'b1;
          rd_addr = p_alloc - ADDR_W'(1);
        end else begin
          // Gap or colour change after the tail: append a run
          res_valid_d = 1'b1;
          if (grab_ok) begin
            if (act_q) top1_d = top1_q + TOP_W'(1);
            else       top0_d = top0_q + TOP_W'(1);
            wr_en    = 1'b1;
            wr_addr  = grab_addr;
            lt_we    = 1'b1;
            lt_wdata = '{cnt: cnt_q + CNT_W'(1), tail: grab_addr};
            res_d    = '{ovf: 1'b0, cnt: cnt_q[SLOT_W:0] + (SLOT_W+1)'(1),
                         slot: grab_addr[SLOT_W-1:0], start: x0_q, len: len_new,
                         color: col_q};
          end else begin
            res_d = '{ovf: 1'b1, cnt: cnt_q[SLOT_W:0], slot: p_q[SLOT_W-1:0],
                      start: rdat_q.start, len: rdat_q.len, color: rdat_q.color};
          end
        end
      end
      ST_PREV: begin
        res_valid_d = 1'b1;
        lt_we       = 1'b1;
        wr_en       = 1'b1;
        if (merge) begin
          // Fold into the preceding slot and release the top slot
          if (act_q) begin
            if (top1_q != '0) top1_d = top1_q - TOP_W'(1);
          end else begin
            if (top0_q != '0) top0_d = top0_q - TOP_W'(1);
          end
          wr_addr  = p_q - ADDR_W'(1);
          wr_data  = '{start: rdat_q.start, len: len_new, color: rdat_q.color};
          lt_wdata = '{cnt: cnt_q - CNT_W'(1), tail: p_q - ADDR_W'(1)};
          res_d    = '{ovf: ovf_q, cnt: cnt_q[SLOT_W:0] - (SLOT_W+1)'(1),
                       slot: p_q[SLOT_W-1:0] - SLOT_W'(1), start: rdat_q.start,
                       len: len_new, color: rdat_q.color};
        end else begin
          res_d = '{ovf: ovf_q, cnt: cnt_q[SLOT_W:0], slot: p_q[SLOT_W-1:0],
                    start: x0_q, len: len_new, color: col_q};
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      top0_q      <= '0;
      top1_q      <= '0;
      res_valid_q <= 1'b0;
      act_q       <= 1'b0;
      lim0_q      <= LIMIT_RESET;
      lim1_q      <= LIMIT_RESET;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      top0_q      <= top0_d;
      top1_q      <= top1_d;
      res_valid_q <= res_valid_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_ACTIVE_POOL: act_q  <= cfg_data_i[0];
          REG_POOL0_LIMIT: lim0_q <= cfg_data_i;
          REG_POOL1_LIMIT: lim1_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    y_q <= y_d; x0_q <= x0_d; x1_q <= x1_d; col_q <= col_d;
    p_q <= p_d; cnt_q <= cnt_d; ovf_q <= ovf_d; mcand_q <= mcand_d;
    res_q <= res_d;
  end

  // Run memory
  always_ff @(posedge clk_i) begin
    if (wr_en) run_mem[wr_addr] <= wr_data;
    if (rd_en) rdat_q <= run_mem[rd_addr];
  end

  // Line table
  always_ff @(posedge clk_i) begin
    if (lt_we) lt_mem[lt_waddr] <= lt_wdata;
    if (lt_re) lent_q <= lt_mem[lt_raddr];
  end

  assign busy            = state_q != ST_IDLE;
  assign cfg_ready_o     = 1'b1;
  assign done_o          = res_valid_q;
  assign pool_overflow_o = res_q.ovf;
  assign line_segments_o = res_q.cnt;
  assign tail_slot_o     = res_q.slot;
  assign tail_start_o    = res_q.start;
  assign tail_length_o   = res_q.len;
  assign tail_color_o    = res_q.color;

`include "scanline_span_merger_macros.svh"

  `SCM_ASSERT_NOW(a_done_idle, done_o, state_q == ST_IDLE,
                  "result while sequencer busy")
  `SCM_ASSERT_NOW(a_top_bound, 1'b1,
                  (top0_q <= TOP_W'(POOL_DEPTH)) && (top1_q <= TOP_W'(POOL_DEPTH)),
                  "pool top past depth")
  `SCM_ASSERT_NOW(a_empty_zero, done_o && line_segments_o == '0,
                  tail_length_o == '0 && tail_color_o == '0,
                  "empty line with tail data")
  `SCM_ASSERT_NOW(a_wr_state, wr_en, state_q != ST_IDLE && state_q != ST_CLEAR,
                  "run write outside work")

endmodule
`default_nettype wire
